[rtl/sts_pkg.sv]
package sts_pkg;

  // Geometry
  localparam int OFFSET_BITS_DEF = 16;
  localparam int TOK_DEPTH       = 4;
  localparam int FIELD_W         = 16;
  localparam int VALUE_W         = 32;
  localparam int KIND_W          = 5;
  localparam int ERR_W           = 2;
  localparam int MODE_W          = 3;

  // Scanner modes
  localparam logic [MODE_W-1:0] MODE_IDLE    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_IDENT   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_NUMBER  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_STRING  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_COMMENT = 3'd4;
  localparam logic [MODE_W-1:0] MODE_OP      = 3'd5;

  // Token kinds
  localparam logic [KIND_W-1:0] K_EOF     = 5'd0;
  localparam logic [KIND_W-1:0] K_NEWLINE = 5'd1;
  localparam logic [KIND_W-1:0] K_NUMBER  = 5'd2;
  localparam logic [KIND_W-1:0] K_STRING  = 5'd3;
  localparam logic [KIND_W-1:0] K_IDENT   = 5'd4;
  localparam logic [KIND_W-1:0] K_VAR     = 5'd5;
  localparam logic [KIND_W-1:0] K_FN      = 5'd6;
  localparam logic [KIND_W-1:0] K_RET     = 5'd7;
  localparam logic [KIND_W-1:0] K_IF      = 5'd8;
  localparam logic [KIND_W-1:0] K_ELSE    = 5'd9;
  localparam logic [KIND_W-1:0] K_END     = 5'd10;
  localparam logic [KIND_W-1:0] K_LOOP    = 5'd11;
  localparam logic [KIND_W-1:0] K_TO      = 5'd12;
  localparam logic [KIND_W-1:0] K_ASM     = 5'd13;
  localparam logic [KIND_W-1:0] K_PLUS    = 5'd14;
  localparam logic [KIND_W-1:0] K_MINUS   = 5'd15;
  localparam logic [KIND_W-1:0] K_STAR    = 5'd16;
  localparam logic [KIND_W-1:0] K_SLASH   = 5'd17;
  localparam logic [KIND_W-1:0] K_EQ      = 5'd18;
  localparam logic [KIND_W-1:0] K_EQEQ    = 5'd19;
  localparam logic [KIND_W-1:0] K_NE      = 5'd20;
  localparam logic [KIND_W-1:0] K_LT      = 5'd21;
  localparam logic [KIND_W-1:0] K_GT      = 5'd22;
  localparam logic [KIND_W-1:0] K_LE      = 5'd23;
  localparam logic [KIND_W-1:0] K_GE      = 5'd24;
  localparam logic [KIND_W-1:0] K_LPAREN  = 5'd25;
  localparam logic [KIND_W-1:0] K_RPAREN  = 5'd26;
  localparam logic [KIND_W-1:0] K_COMMA   = 5'd27;
  localparam logic [KIND_W-1:0] K_AT      = 5'd28;
  localparam logic [KIND_W-1:0] K_DOT     = 5'd29;
  localparam logic [KIND_W-1:0] K_ERROR   = 5'd30;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
  localparam logic [ERR_W-1:0] ERR_OPEN_STR  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_NO_EQUALS = 2'd2;
  localparam logic [ERR_W-1:0] ERR_BAD_CHAR  = 2'd3;

  // Pending operator codes
  localparam logic [1:0] OP_ASSIGN = 2'd0;
  localparam logic [1:0] OP_LESS   = 2'd1;
  localparam logic [1:0] OP_MORE   = 2'd2;
  localparam logic [1:0] OP_BANG   = 2'd3;

  // Characters
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [ERR_W-1:0]   err_code;
    logic [FIELD_W-1:0] start_offset;
    logic [FIELD_W-1:0] length;
    logic [FIELD_W-1:0] line_no;
    logic [VALUE_W-1:0] number_value;
    logic               last;
  } tok_t;

  // Build one token; position fields keep their low 16 bits
  function automatic tok_t mk_tok(logic [KIND_W-1:0] kind, logic [ERR_W-1:0] err,
                                  logic [31:0] start, logic [31:0] len,
                                  logic [31:0] line, logic [VALUE_W-1:0] val);
    tok_t t;
    t.kind         = kind;
    t.err_code     = err;
    t.start_offset = start[FIELD_W-1:0];
    t.length       = len[FIELD_W-1:0];
    t.line_no      = line[FIELD_W-1:0];
    t.number_value = val;
    t.last         = 1'b0;
    return t;
  endfunction

  // Keyword lookup on length and the first four bytes, low byte first
  function automatic logic [KIND_W-1:0] ident_kind(logic [31:0] len, logic [31:0] prefix);
    logic [KIND_W-1:0] k;
    k = K_IDENT;
    if      (len == 32'd3 && prefix == 32'h0072_6176) k = K_VAR;
    else if (len == 32'd2 && prefix == 32'h0000_6E66) k = K_FN;
    else if (len == 32'd3 && prefix == 32'h0074_6572) k = K_RET;
    else if (len == 32'd2 && prefix == 32'h0000_6669) k = K_IF;
    else if (len == 32'd4 && prefix == 32'h6573_6C65) k = K_ELSE;
    else if (len == 32'd3 && prefix == 32'h0064_6E65) k = K_END;
    else if (len == 32'd4 && prefix == 32'h706F_6F6C) k = K_LOOP;
    else if (len == 32'd2 && prefix == 32'h0000_6F74) k = K_TO;
    else if (len == 32'd3 && prefix == 32'h006D_7361) k = K_ASM;
    return k;
  endfunction

  function automatic logic [KIND_W-1:0] single_kind(logic [1:0] op);
    logic [KIND_W-1:0] k;
    unique case (op)
      OP_ASSIGN: k = K_EQ;
      OP_LESS:   k = K_LT;
      OP_MORE:   k = K_GT;
      default:   k = K_EOF;
    endcase
    return k;
  endfunction

  function automatic logic [KIND_W-1:0] double_kind(logic [1:0] op);
    logic [KIND_W-1:0] k;
    unique case (op)
      OP_ASSIGN: k = K_EQEQ;
      OP_LESS:   k = K_LE;
      OP_MORE:   k = K_GE;
      default:   k = K_NE;
    endcase
    return k;
  endfunction

endpackage

[rtl/sts_in_if.sv]
interface sts_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] ch;

  modport source (output valid, output func, output ch, input ready);
  modport sink (input valid, input func, input ch, output ready);
endinterface

[rtl/sts_out_if.sv]
interface sts_out_if;
  import sts_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [ERR_W-1:0]   err_code;
  logic [FIELD_W-1:0] start_offset;
  logic [FIELD_W-1:0] length;
  logic [FIELD_W-1:0] line_no;
  logic [VALUE_W-1:0] number_value;
  logic               last;

  modport source (output valid, output kind, output err_code, output start_offset,
                  output length, output line_no, output number_value, output last,
                  input ready);
  modport sink (input valid, input kind, input err_code, input start_offset,
                input length, input line_no, input number_value, input last,
                output ready);
endinterface

[rtl/script_token_scanner_core.sv]
// Streaming tokenizer: one source byte (or end-of-source mark) per input item, tokens out
// one per cycle while the consumer is ready. The scanner state and the lexing decision for
// an item are evaluated in the cycle it is accepted, and its tokens (at most two) land in a
// 4-entry token queue, so with an empty queue the first token of an item is visible on the
// output the cycle after acceptance. Input items are taken one per cycle whenever the queue
// has at least two free slots; an item that yields two tokens takes two output slots, so
// sustained input rate is one item per cycle as long as the consumer drains one token per
// cycle and items average at most one token. End of source always yields EOF (after any
// pending token) and returns position to 0 and line to 1. Positions, lengths and lines
// saturate at 2^OFFSET_BITS-1 and are reported in their low 16 bits.
module script_token_scanner_core #(
  parameter int OFFSET_BITS = sts_pkg::OFFSET_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  sts_in_if.sink    src,
  sts_out_if.source tok
);
  import sts_pkg::*;

  localparam int PTR_W = $clog2(TOK_DEPTH);
  localparam int CNT_W = $clog2(TOK_DEPTH + 1);

  function automatic logic [OFFSET_BITS-1:0] sat_inc(logic [OFFSET_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Scanner state
  logic [MODE_W-1:0]      mode, mode_next;
  logic [OFFSET_BITS-1:0] pos, pos_next;
  logic [OFFSET_BITS-1:0] line, line_next;
  logic [OFFSET_BITS-1:0] tstart, tstart_next;
  logic [OFFSET_BITS-1:0] tlen, tlen_next;
  logic [VALUE_W-1:0]     accum, accum_next;
  logic [31:0]            prefix, prefix_next;
  logic [1:0]             pop, pop_next;

  // Token queue
  tok_t             q [TOK_DEPTH];
  logic [PTR_W-1:0] head, tail;
  logic [CNT_W-1:0] count, count_next;

  logic       acc;
  logic       drain;
  logic       flush_vld;
  tok_t       flush_tok;
  logic [1:0] n;
  tok_t       res [2];

  assign acc       = src.valid && src.ready;
  assign drain     = tok.valid && tok.ready;
  assign src.ready = (count <= CNT_W'(TOK_DEPTH - 2));

  // Close whatever token is pending in the registered state
  always_comb begin
    flush_vld = 1'b1;
    flush_tok = mk_tok(K_ERROR, ERR_OPEN_STR, 32'(tstart), 32'd0, 32'(line), '0);
    unique case (mode)
      MODE_IDENT:
        flush_tok = mk_tok(ident_kind(32'(tlen), prefix), ERR_NONE, 32'(tstart),
                           32'(tlen), 32'(line), '0);
      MODE_NUMBER:
        flush_tok = mk_tok(K_NUMBER, ERR_NONE, 32'(tstart), 32'(tlen), 32'(line), accum);
      MODE_STRING: ;
      MODE_OP:
        if (pop == OP_BANG) begin
          flush_tok = mk_tok(K_ERROR, ERR_NO_EQUALS, 32'(tstart), 32'd0, 32'(line), '0);
        end else begin
          flush_tok = mk_tok(single_kind(pop), ERR_NONE, 32'(tstart), 32'd1,
                             32'(line), '0);
        end
      default: flush_vld = 1'b0;
    endcase
  end

  // Lex one item: continue the pending token, else flush it and start a new one
  always_comb begin
    logic                   consumed;
    logic [OFFSET_BITS-1:0] ln;
    logic [7:0]             c;
    logic                   st_vld;
    tok_t                   st_tok;

    c           = src.ch;
    consumed    = 1'b0;
    ln          = line;
    st_vld      = 1'b0;
    st_tok      = '0;
    mode_next   = mode;
    pos_next    = pos;
    tstart_next = tstart;
    tlen_next   = tlen;
    accum_next  = accum;
    prefix_next = prefix;
    pop_next    = pop;
    n           = 2'd0;
    res[0]      = '0;
    res[1]      = '0;

    if (src.func) begin
      // End of source: pending token, then EOF, then rewind
      if (flush_vld) begin
        res[n[0]] = flush_tok;
        n         = n + 2'd1;
      end
      res[n[0]]   = mk_tok(K_EOF, ERR_NONE, 32'(pos), 32'd0, 32'(line), '0);
      n           = n + 2'd1;
      mode_next   = MODE_IDLE;
      pos_next    = '0;
      ln          = OFFSET_BITS'(1);
      tlen_next   = '0;
      accum_next  = '0;
      prefix_next = '0;
      pop_next    = OP_ASSIGN;
    end else begin
      // Extend the pending token where this byte belongs to it
      unique case (mode)
        MODE_IDENT:
          case (c) inside
            [CH_LO_A:CH_LO_Z], [CH_UP_A:CH_UP_Z], CH_UNDER, [CH_ZERO:CH_NINE]: begin
              if (tlen < OFFSET_BITS'(4)) begin
                prefix_next = prefix | (32'(c) << {tlen[1:0], 3'b000});
              end
              tlen_next = sat_inc(tlen);
              consumed  = 1'b1;
            end
            default: ;
          endcase
        MODE_NUMBER:
          if (c >= CH_ZERO && c <= CH_NINE) begin
            accum_next = (accum << 3) + (accum << 1) + {28'd0, c[3:0]};
            tlen_next  = sat_inc(tlen);
            consumed   = 1'b1;
          end
        MODE_STRING: begin
          if (c == CH_QUOTE) begin
            res[n[0]] = mk_tok(K_STRING, ERR_NONE, 32'(tstart), 32'(tlen), 32'(line), '0);
            n         = n + 2'd1;
            mode_next = MODE_IDLE;
          end else begin
            if (c == CH_NL) begin
              ln = sat_inc(line);
            end
            tlen_next = sat_inc(tlen);
          end
          consumed = 1'b1;
        end
        MODE_COMMENT:
          consumed = (c != CH_NL);
        MODE_OP:
          if (c == CH_EQ) begin
            res[n[0]] = mk_tok(double_kind(pop), ERR_NONE, 32'(tstart), 32'd2,
                               32'(line), '0);
            n         = n + 2'd1;
            mode_next = MODE_IDLE;
            consumed  = 1'b1;
          end
        default: ;
      endcase

      if (!consumed) begin
        if (flush_vld) begin
          res[n[0]] = flush_tok;
          n         = n + 2'd1;
        end
        mode_next = MODE_IDLE;
        // Start a new token with this byte
        case (c) inside
          CH_SPACE, CH_TAB, CH_CR: ;
          CH_SEMI: mode_next = MODE_COMMENT;
          CH_NL: begin
            ln     = sat_inc(line);
            st_vld = 1'b1;
            st_tok = mk_tok(K_NEWLINE, ERR_NONE, 32'(pos), 32'd1, 32'(ln), '0);
          end
          CH_QUOTE: begin
            mode_next   = MODE_STRING;
            tstart_next = sat_inc(pos);
            tlen_next   = '0;
          end
          CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_LPAREN, CH_RPAREN, CH_COMMA, CH_AT,
          CH_DOT: begin
            st_vld = 1'b1;
            st_tok = mk_tok(K_PLUS, ERR_NONE, 32'(pos), 32'd1, 32'(line), '0);
            case (c)
              CH_MINUS:  st_tok.kind = K_MINUS;
              CH_STAR:   st_tok.kind = K_STAR;
              CH_SLASH:  st_tok.kind = K_SLASH;
              CH_LPAREN: st_tok.kind = K_LPAREN;
              CH_RPAREN: st_tok.kind = K_RPAREN;
              CH_COMMA:  st_tok.kind = K_COMMA;
              CH_AT:     st_tok.kind = K_AT;
              CH_DOT:    st_tok.kind = K_DOT;
              default:   ;
            endcase
          end
          CH_EQ, CH_LT, CH_GT, CH_BANG: begin
            mode_next   = MODE_OP;
            tstart_next = pos;
            case (c)
              CH_EQ:   pop_next = OP_ASSIGN;
              CH_LT:   pop_next = OP_LESS;
              CH_GT:   pop_next = OP_MORE;
              default: pop_next = OP_BANG;
            endcase
          end
          [CH_LO_A:CH_LO_Z], [CH_UP_A:CH_UP_Z], CH_UNDER: begin
            mode_next   = MODE_IDENT;
            tstart_next = pos;
            tlen_next   = OFFSET_BITS'(1);
            prefix_next = 32'(c);
          end
          [CH_ZERO:CH_NINE]: begin
            mode_next   = MODE_NUMBER;
            tstart_next = pos;
            tlen_next   = OFFSET_BITS'(1);
            accum_next  = {28'd0, c[3:0]};
          end
          default: begin
            st_vld = 1'b1;
            st_tok = mk_tok(K_ERROR, ERR_BAD_CHAR, 32'(pos), 32'd0, 32'(line), '0);
          end
        endcase
        if (st_vld) begin
          res[n[0]] = st_tok;
          n         = n + 2'd1;
        end
      end
      pos_next = sat_inc(pos);
    end

    line_next = ln;
    // Mark the final token of this item
    if (n != 2'd0) begin
      res[n[0] - 1'b1].last = 1'b1;
    end
  end

  // Advance the scanner state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_IDLE;
      pos    <= '0;
      line   <= OFFSET_BITS'(1);
      tstart <= '0;
      tlen   <= '0;
      accum  <= '0;
      prefix <= '0;
      pop    <= OP_ASSIGN;
    end else if (acc) begin
      mode   <= mode_next;
      pos    <= pos_next;
      line   <= line_next;
      tstart <= tstart_next;
      tlen   <= tlen_next;
      accum  <= accum_next;
      prefix <= prefix_next;
      pop    <= pop_next;
    end
  end

  // Token queue storage: push up to two items, pop one
  always_ff @(posedge clk) begin
    if (acc && n != 2'd0) begin
      q[tail] <= res[0];
    end
    if (acc && n == 2'd2) begin
      q[tail + 1'b1] <= res[1];
    end
  end

  always_comb begin
    count_next = count;
    if (acc) begin
      count_next = count_next + CNT_W'(n);
    end
    if (drain) begin
      count_next = count_next - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (acc) begin
        tail <= tail + PTR_W'(n);
      end
      if (drain) begin
        head <= head + 1'b1;
      end
    end
  end

  // Drive the head item
  assign tok.valid        = (count != '0);
  assign tok.kind         = q[head].kind;
  assign tok.err_code     = q[head].err_code;
  assign tok.start_offset = q[head].start_offset;
  assign tok.length       = q[head].length;
  assign tok.line_no      = q[head].line_no;
  assign tok.number_value = q[head].number_value;
  assign tok.last         = q[head].last;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TOK_DEPTH))
    else $error("token queue overfilled");

  a_eof_rewind: assert property (@(posedge clk) disable iff (rst)
    acc && src.func |=> pos == '0 && line == OFFSET_BITS'(1) && mode == MODE_IDLE)
    else $error("end of source did not rewind the scanner");

  a_eof_queued: assert property (@(posedge clk) disable iff (rst)
    acc && src.func |=> count != '0)
    else $error("end of source left no token queued");

  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    line != '0)
    else $error("line count reached zero");
`endif

endmodule
